// ===== rtl/rcb_pkg.sv =====
// shared types, constants and the border fold function of the convolution block
package rcb_pkg;

	localparam int MAX_W = 64;
	localparam int MAX_H = 64;
	localparam int MAX_K = 7;
	localparam int XW = $clog2(MAX_W);
	localparam int YW = $clog2(MAX_H);
	localparam int FRAME_DEPTH = MAX_W * MAX_H;
	localparam int FRAME_AW = $clog2(FRAME_DEPTH);
	localparam int COEF_DEPTH = MAX_K * MAX_K;
	localparam int COEF_AW = $clog2(COEF_DEPTH);

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_COEF    = 2'd1,
		KIND_COMPUTE = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_EVEN    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BM_CLAMP    = 2'd0,
		BM_WRAP     = 2'd1,
		BM_MIRROR   = 2'd2,
		BM_CONSTANT = 2'd3
	} border_mode_t;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_KERNEL = 3'd2,
		REG_STRIDE = 3'd3,
		REG_GAIN   = 3'd4,
		REG_BIAS   = 3'd5,
		REG_MODE   = 3'd6,
		REG_COLOUR = 3'd7
	} reg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_MUL,
		S_CLAMP,
		S_POST
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [5:0]         pos_x;
		logic [5:0]         pos_y;
		logic [7:0]         in_red;
		logic [7:0]         in_green;
		logic [7:0]         in_blue;
		logic [2:0]         coef_col;
		logic [2:0]         coef_row;
		logic signed [15:0] coef_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		status_t    status;
	} out_item_t;

	typedef struct packed {
		logic       outside;
		logic [5:0] coord;
	} fold_t;

	// map one source coordinate into the image through the border mode
	function automatic fold_t fold(input logic signed [10:0] c, input logic [6:0] n,
			input border_mode_t mode);
		logic signed [10:0] nn;
		logic signed [10:0] pp;
		logic signed [10:0] m;
		fold_t r;
		nn = $signed({4'b0, n});
		pp = (nn <<< 1) - 11'sd2;
		m = c;
		r.outside = 1'b0;
		r.coord = '0;
		if (c >= 11'sd0 && c < nn) begin
			r.coord = c[5:0];
		end else begin
			case (mode)
				BM_WRAP: begin
					for (int t = 0; t < 4; t++) begin
						if (m < 11'sd0) m = m + nn;
						else if (m >= nn) m = m - nn;
					end
					r.coord = m[5:0];
				end
				BM_MIRROR: begin
					if (pp != 11'sd0) begin
						for (int t = 0; t < 4; t++) begin
							if (m < 11'sd0) m = m + pp;
							else if (m >= pp) m = m - pp;
						end
						if (m >= nn) m = pp - m;
						r.coord = m[5:0];
					end
				end
				BM_CONSTANT: r.outside = 1'b1;
				default: begin
					if (c < 11'sd0) r.coord = '0;
					else r.coord = 6'(nn - 11'sd1);
				end
			endcase
		end
		return r;
	endfunction

endpackage

// ===== rtl/rcb_ram.sv =====
// generic single-port synchronous ram with registered read
module rcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/rgb_convolution_with_border_modes.sv =====
// top level of the strided rgb convolution with border modes
//
// channel | direction | handshake        | payload
// in      | input     | in_valid/stall   | in_item_t: kind, position, pixel, coefficient
// out     | output    | out_valid/stall  | out_item_t: three channels and status
// cfg     | input     | cfg_valid/ready  | cfg_index (3 bits), cfg_data (24 bits)
//
// a load is written to its ram when it is accepted; a compute passes through the accept, a read
// of the frame ram for each tap (one per cycle from the single-port frame ram), a drain until the
// tap pipeline is empty, scaling of each channel in turn on one shared multiplier and the load of
// the output register; error results go from the accept straight to the output register
// reset sets the registers to their listed values; frame and coefficient rams are not cleared
// in_stall is high while a compute is in progress or its result waits for the output register
// cfg_ready is always high
module rgb_convolution_with_border_modes
	import rcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// configuration registers
	logic [6:0]         width_q, height_q;
	logic [2:0]         kernel_q;
	logic [3:0]         stride_q;
	logic signed [15:0] gain_q, bias_q;
	border_mode_t       mode_q;
	logic [23:0]        colour_q;

	state_t state_q, state_d;

	logic [9:0]         cx_q, cy_q;
	logic [2:0]         i_q, j_q;
	logic [1:0]         ch_q;
	status_t            status_q;
	logic signed [31:0] acc_q [3];
	logic signed [47:0] prod_q;
	logic [7:0]         res_q [3];
	logic               v_s1, out_s1, v_s2;
	logic signed [24:0] prod_s2 [3];
	out_item_t          out_q;
	logic               out_valid_q;

	// control decode
	logic in_acc, is_compute, issue, last, post, bad_even, bad_out;
	logic [6:0] w_eff, h_eff;
	logic [3:0] s_eff;
	logic [2:0] half;
	logic [9:0] cx_d, cy_d;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && !in_stall;
	assign is_compute = in_data.kind == KIND_COMPUTE;
	assign w_eff = (width_q == 7'd0) ? 7'd1 : ((width_q > 7'(MAX_W)) ? 7'(MAX_W) : width_q);
	assign h_eff = (height_q == 7'd0) ? 7'd1 :
		((height_q > 7'(MAX_H)) ? 7'(MAX_H) : height_q);
	assign s_eff = (stride_q == 4'd0) ? 4'd1 : stride_q;
	assign half = kernel_q >> 1;
	assign cx_d = 10'(in_data.pos_x) * 10'(s_eff);
	assign cy_d = 10'(in_data.pos_y) * 10'(s_eff);
	assign bad_even = !kernel_q[0];
	assign bad_out = (cx_d >= 10'(w_eff)) || (cy_d >= 10'(h_eff));
	assign last = (i_q == kernel_q - 3'd1) && (j_q == kernel_q - 3'd1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && is_compute) begin
					state_d = (bad_even || bad_out) ? S_POST : S_RUN;
				end
			end
			S_RUN:   if (last) state_d = S_DRAIN;
			S_DRAIN: if (!v_s1 && !v_s2) state_d = S_MUL;
			S_MUL:   state_d = S_CLAMP;
			S_CLAMP: state_d = (ch_q == 2'd2) ? S_POST : S_MUL;
			S_POST:  if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = state_q != S_IDLE;
		issue = state_q == S_RUN;
		post = (state_q == S_POST) && (!out_valid_q || !out_stall);
	end

	// source coordinates of the current tap
	logic signed [10:0] c_x, c_y;
	fold_t fx, fy;
	assign c_x = $signed({1'b0, cx_q}) + $signed({8'b0, i_q}) - $signed({8'b0, half});
	assign c_y = $signed({1'b0, cy_q}) + $signed({8'b0, j_q}) - $signed({8'b0, half});
	assign fx = fold(c_x, w_eff, mode_q);
	assign fy = fold(c_y, h_eff, mode_q);

	// frame ram port
	logic                frame_we;
	logic [FRAME_AW-1:0] frame_addr;
	logic [23:0]         frame_rdata;
	assign frame_we = in_acc && in_data.kind == KIND_PIXEL;
	assign frame_addr = issue ? FRAME_AW'({fy.coord[YW-1:0], fx.coord[XW-1:0]}) :
		FRAME_AW'({in_data.pos_y, in_data.pos_x});

	rcb_ram #(.WIDTH(24), .DEPTH(FRAME_DEPTH)) u_frame (
		.clk   (clk),
		.we    (frame_we),
		.addr  (frame_addr),
		.wdata ({in_data.in_red, in_data.in_green, in_data.in_blue}),
		.rdata (frame_rdata)
	);

	// coefficient ram port
	logic               coef_we;
	logic [COEF_AW-1:0] coef_addr;
	logic [15:0]        coef_rdata;
	assign coef_we = in_acc && in_data.kind == KIND_COEF &&
		in_data.coef_col < 3'(MAX_K) && in_data.coef_row < 3'(MAX_K);
	assign coef_addr = issue ? (COEF_AW'(i_q) * COEF_AW'(MAX_K) + COEF_AW'(j_q)) :
		(COEF_AW'(in_data.coef_col) * COEF_AW'(MAX_K) + COEF_AW'(in_data.coef_row));

	rcb_ram #(.WIDTH(16), .DEPTH(COEF_DEPTH)) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.addr  (coef_addr),
		.wdata (in_data.coef_value),
		.rdata (coef_rdata)
	);

	// weighting of the fetched tap
	logic [23:0]        pix;
	logic signed [15:0] coef;
	logic signed [24:0] tap [3];
	assign pix = out_s1 ? colour_q : frame_rdata;
	assign coef = $signed(coef_rdata);
	assign tap[0] = 25'($signed({1'b0, pix[23:16]})) * 25'(coef);
	assign tap[1] = 25'($signed({1'b0, pix[15:8]})) * 25'(coef);
	assign tap[2] = 25'($signed({1'b0, pix[7:0]})) * 25'(coef);

	// scale, offset and clamp of one channel
	logic signed [48:0] total;
	logic signed [32:0] shifted;
	logic [7:0]         clamped;
	assign total = 49'(prod_q) + (49'(bias_q) <<< 8);
	assign shifted = 33'(total >>> 16);
	always_comb begin
		if (total <= 49'sd0) clamped = 8'd0;
		else if (shifted > 33'sd255) clamped = 8'd255;
		else clamped = shifted[7:0];
	end

	// state and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			width_q <= 7'd64;
			height_q <= 7'd64;
			kernel_q <= 3'd3;
			stride_q <= 4'd1;
			gain_q <= 16'sd256;
			bias_q <= 16'sd0;
			mode_q <= BM_CLAMP;
			colour_q <= 24'd0;
		end else begin
			state_q <= state_d;
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (post) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (reg_index_t'(cfg_index))
					REG_WIDTH:  width_q <= cfg_data[6:0];
					REG_HEIGHT: height_q <= cfg_data[6:0];
					REG_KERNEL: kernel_q <= cfg_data[2:0];
					REG_STRIDE: stride_q <= cfg_data[3:0];
					REG_GAIN:   gain_q <= $signed(cfg_data[15:0]);
					REG_BIAS:   bias_q <= $signed(cfg_data[15:0]);
					REG_MODE:   mode_q <= border_mode_t'(cfg_data[1:0]);
					REG_COLOUR: colour_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// request setup
		if (state_q == S_IDLE && in_acc && is_compute) begin
			cx_q <= cx_d;
			cy_q <= cy_d;
			i_q <= '0;
			j_q <= '0;
			ch_q <= '0;
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= '0;
				res_q[c] <= '0;
			end
			status_q <= bad_even ? ST_EVEN : (bad_out ? ST_OUTSIDE : ST_OK);
		end
		// tap counters
		if (issue) begin
			if (j_q == kernel_q - 3'd1) begin
				j_q <= '0;
				i_q <= i_q + 3'd1;
			end else begin
				j_q <= j_q + 3'd1;
			end
		end
		out_s1 <= fx.outside || fy.outside;
		// multiply and accumulate
		if (v_s1) begin
			for (int c = 0; c < 3; c++) prod_s2[c] <= tap[c];
		end
		if (v_s2) begin
			for (int c = 0; c < 3; c++) acc_q[c] <= acc_q[c] + 32'(prod_s2[c]);
		end
		// final scaling, one channel at a time
		if (state_q == S_MUL) begin
			prod_q <= 48'(acc_q[ch_q]) * 48'(gain_q);
		end
		if (state_q == S_CLAMP) begin
			res_q[ch_q] <= clamped;
			ch_q <= ch_q + 2'd1;
		end
		// output register
		if (post) begin
			out_q.out_red <= res_q[0];
			out_q.out_green <= res_q[1];
			out_q.out_blue <= res_q[2];
			out_q.status <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
